/* rtl/core/lsps_pkg.sv */
// Shared types and constants for the line sensor PID steering block.
// Used by every module under rtl/core; depends on nothing else.
package lsps_pkg;

  localparam int unsigned PropGainW  = 10;
  localparam int unsigned IntegGainW = 8;
  localparam int unsigned DerivGainW = 10;
  localparam int unsigned SpeedW     = 8;
  localparam int unsigned SensorW    = 5;
  localparam int unsigned ErrorW     = 4;
  localparam int unsigned DeltaW     = 5;
  localparam int unsigned CfgIndexW  = 2;
  localparam int unsigned CfgDataW   = 10;

  localparam logic [PropGainW-1:0]  PropGainRst  = 10'd175;
  localparam logic [IntegGainW-1:0] IntegGainRst = 8'd0;
  localparam logic [DerivGainW-1:0] DerivGainRst = 10'd100;
  localparam logic [SpeedW-1:0]     BaseSpeedRst = 8'd180;

  typedef enum logic [CfgIndexW-1:0] {
    CfgPropGain  = 2'd0,
    CfgIntegGain = 2'd1,
    CfgDerivGain = 2'd2,
    CfgBaseSpeed = 2'd3
  } cfg_reg_e;

  // Decoded error of one reading, as it moves down the pipeline.
  typedef struct packed {
    logic signed [ErrorW-1:0] err;
    logic signed [DeltaW-1:0] delta;
    logic                     lost;
  } err_stage_t;

endpackage

/* rtl/core/lsps_error_track.sv */
// Sensor decode, held error and saturating error sum.
// Depends on lsps_pkg.
module lsps_error_track #(
  parameter int unsigned SumW = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              take_i,
  input  logic [lsps_pkg::SensorW-1:0]      sensor_bits_i,
  output lsps_pkg::err_stage_t              stage_o,
  output logic signed [SumW-1:0]            sum_o
);
  import lsps_pkg::*;

  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

  logic signed [ErrorW-1:0] held_error_q, held_error_d;
  logic signed [SumW-1:0]   error_sum_q, error_sum_d;
  logic signed [ErrorW-1:0] err;
  logic signed [SumW:0]     sum_wide;
  logic signed [SumW-1:0]   sum_sat;

  always_comb begin
    case (sensor_bits_i)
      5'h10:   err = 4'sd4;
      5'h18:   err = 4'sd3;
      5'h08:   err = 4'sd2;
      5'h0C:   err = 4'sd1;
      5'h04:   err = 4'sd0;
      5'h06:   err = -4'sd1;
      5'h02:   err = -4'sd2;
      5'h03:   err = -4'sd3;
      5'h01:   err = -4'sd4;
      // All dark: steer hard towards the side where the line was last seen.
      5'h00:   err = held_error_q[ErrorW-1] ? -4'sd5 : 4'sd5;
      default: err = held_error_q;
    endcase
  end

  always_comb begin
    sum_wide = (SumW+1)'(error_sum_q) + (SumW+1)'(err);
    if (sum_wide[SumW] != sum_wide[SumW-1]) begin
      sum_sat = sum_wide[SumW] ? SumMin : SumMax;
    end else begin
      sum_sat = sum_wide[SumW-1:0];
    end
  end

  assign held_error_d = take_i ? err : held_error_q;
  assign error_sum_d  = take_i ? sum_sat : error_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_error_q <= '0;
      error_sum_q  <= '0;
    end else begin
      held_error_q <= held_error_d;
      error_sum_q  <= error_sum_d;
    end
  end

  assign stage_o.err   = err;
  assign stage_o.delta = DeltaW'(err) - DeltaW'(held_error_q);
  assign stage_o.lost  = (sensor_bits_i == '0);
  assign sum_o         = sum_sat;

endmodule

/* rtl/core/lsps_speed_map.sv */
// Maps a PID value and the base speed to the two clamped wheel duties.
// Depends on lsps_pkg.
module lsps_speed_map #(
  parameter int unsigned PidW = 35
) (
  input  logic signed [PidW-1:0]        pid_i,
  input  logic [lsps_pkg::SpeedW-1:0]   base_i,
  output logic [lsps_pkg::SpeedW-1:0]   left_o,
  output logic [lsps_pkg::SpeedW-1:0]   right_o
);
  import lsps_pkg::*;

  // Beyond +-2047 the PID value drives both wheels into the rails, so it is
  // clamped to 12 bits before the divide by six.
  localparam logic signed [PidW-1:0] PidLim = PidW'(2047);
  localparam logic [12:0]            Offs   = 13'd2052;  // 342 * 6
  localparam logic [13:0]            Recip  = 14'd10923; // ceil(2^16 / 6)
  localparam logic signed [10:0]     QOffs  = 11'sd342;

  logic signed [11:0] pid_c;

  function automatic logic [SpeedW-1:0] wheel(input logic signed [11:0] x,
                                              input logic [SpeedW-1:0] base);
    logic [12:0]        u;
    logic [26:0]        prod;
    logic signed [10:0] spd;
    begin
      u    = 13'(x) + Offs;
      prod = 27'(u) * 27'(Recip);
      spd  = $signed(11'(prod[26:16])) - QOffs + $signed(11'({1'b0, base}));
      if (spd < 0) begin
        wheel = '0;
      end else if (spd > 11'sd255) begin
        wheel = '1;
      end else begin
        wheel = spd[SpeedW-1:0];
      end
    end
  endfunction

  always_comb begin
    if (pid_i > PidLim) begin
      pid_c = 12'sd2047;
    end else if (pid_i < -PidLim) begin
      pid_c = -12'sd2047;
    end else begin
      pid_c = pid_i[11:0];
    end
  end

  assign left_o  = wheel(-pid_c, base_i);
  assign right_o = wheel(pid_c, base_i);

endmodule

/* rtl/core/line_sensor_pid_steering.sv */
// Top level of the line sensor PID steering block.
// Depends on lsps_pkg, lsps_error_track and lsps_speed_map.
//
// Usage: each transfer on the s_axis channel carries one 5-bit sensor
// reading; each reading gives exactly one transfer on m_axis with the two
// wheel duties and the decoded error, and line_lost in tuser.
// The cfg channel writes the gains and the base speed; it is always ready
// and should be used only while no reading is in flight.
// There are three register stages: the decode and integral update, the
// three gain multiplies, then the divide by six and clamp. m_axis_tvalid
// rises once the reading has passed all three. While the output is not
// stalled one reading is taken every cycle; the held error and error
// sum are updated at the accepting edge, so readings chain without gaps.
// Each pipeline stage has its own valid bit, so when m_axis_tready is low
// the earlier stages keep filling; s_axis_tready only drops once all
// three stages hold data.
// Reset clears the pipeline, the held error and the error sum, and loads
// the register reset values.
module line_sensor_pid_steering #(
  parameter int unsigned INTEGRAL_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,  // [4:0] sensor_bits
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [7:0] left_speed, [15:8] right_speed, [19:16] line_error, [23:20] zero
  output logic [23:0]                         m_axis_tdata,
  output logic                                m_axis_tuser,  // [0] line_lost
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lsps_pkg::CfgIndexW-1:0]      cfg_index_i,
  input  logic [lsps_pkg::CfgDataW-1:0]       cfg_data_i
);
  import lsps_pkg::*;

  localparam int unsigned SumW = INTEGRAL_BITS;
  localparam int unsigned PidW = SumW + 11;

  logic [PropGainW-1:0]  prop_gain_q;
  logic [IntegGainW-1:0] integ_gain_q;
  logic [DerivGainW-1:0] deriv_gain_q;
  logic [SpeedW-1:0]     base_speed_q;

  logic v1_q, v2_q, v3_q;
  logic rdy2, rdy3, take;

  err_stage_t             trk_stage, s1_q;
  logic signed [SumW-1:0] trk_sum, s1_sum_q;

  logic signed [ErrorW-1:0] s2_err_q;
  logic                     s2_lost_q;
  logic signed [PidW-1:0]   pid_d, pid_q;

  logic signed [14:0]     p_prop;
  logic signed [SumW+8:0] p_int;
  logic signed [15:0]     p_der;

  logic [SpeedW-1:0] left_spd, right_spd;
  logic [23:0]       tdata_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q  <= PropGainRst;
      integ_gain_q <= IntegGainRst;
      deriv_gain_q <= DerivGainRst;
      base_speed_q <= BaseSpeedRst;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgPropGain:  prop_gain_q  <= cfg_data_i[PropGainW-1:0];
        CfgIntegGain: integ_gain_q <= cfg_data_i[IntegGainW-1:0];
        CfgDerivGain: deriv_gain_q <= cfg_data_i[DerivGainW-1:0];
        CfgBaseSpeed: base_speed_q <= cfg_data_i[SpeedW-1:0];
        default: ;
      endcase
    end
  end

  // Per-stage ready: a stage can load when it is empty or drains this cycle.
  assign rdy3          = !v3_q || m_axis_tready;
  assign rdy2          = !v2_q || rdy3;
  assign s_axis_tready = !v1_q || rdy2;
  assign take          = s_axis_tvalid && s_axis_tready;

  lsps_error_track #(
    .SumW(SumW)
  ) u_track (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .sensor_bits_i(s_axis_tdata[SensorW-1:0]),
    .stage_o      (trk_stage),
    .sum_o        (trk_sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        v1_q <= s_axis_tvalid;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_q     <= trk_stage;
      s1_sum_q <= trk_sum;
    end
  end

  assign p_prop = $signed({1'b0, prop_gain_q}) * s1_q.err;
  assign p_int  = $signed({1'b0, integ_gain_q}) * s1_sum_q;
  assign p_der  = $signed({1'b0, deriv_gain_q}) * s1_q.delta;
  assign pid_d  = PidW'(p_prop) + PidW'(p_int) + PidW'(p_der);

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      pid_q     <= pid_d;
      s2_err_q  <= s1_q.err;
      s2_lost_q <= s1_q.lost;
    end
  end

  lsps_speed_map #(
    .PidW(PidW)
  ) u_speed (
    .pid_i  (pid_q),
    .base_i (base_speed_q),
    .left_o (left_spd),
    .right_o(right_spd)
  );

  assign tdata_d = {4'b0000, s2_err_q, right_spd, left_spd};

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      m_axis_tdata <= tdata_d;
      m_axis_tuser <= s2_lost_q;
    end
  end

  assign m_axis_tvalid = v3_q;

endmodule

/* rtl/core/lsps_checker.sv */
// Port-level checks for the line sensor PID steering block, and the bind
// that attaches them to the top level. Depends on lsps_pkg.
module lsps_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic [7:0]                          s_axis_tdata,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [23:0]                         m_axis_tdata,
  input logic                                m_axis_tuser,
  input logic                                cfg_valid_i,
  input logic                                cfg_ready_o,
  input logic [lsps_pkg::CfgIndexW-1:0]      cfg_index_i,
  input logic [lsps_pkg::CfgDataW-1:0]       cfg_data_i
);
  import lsps_pkg::*;

  // A stalled result must stay put until it is transferred.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // With nothing waiting at the output the pipeline cannot be full.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output");

  // A lost line always reports a full-scale error.
  a_lost_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[19:16] == 4'h5 || m_axis_tdata[19:16] == 4'hB)
    else $error("line lost without a full-scale error");

  // The error never leaves -5..5 and the pad bits stay clear.
  a_error_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23:20] == 4'h0 &&
      m_axis_tdata[19:16] != 4'h6 && m_axis_tdata[19:16] != 4'h7 &&
      m_axis_tdata[19:16] != 4'h8 && m_axis_tdata[19:16] != 4'h9 &&
      m_axis_tdata[19:16] != 4'hA)
    else $error("line error out of range");

endmodule

bind line_sensor_pid_steering lsps_checker u_lsps_checker (.*);
